// ===== src/sha1md_pkg.sv =====
// Shared constants, types and helpers for the SHA-1 digest block.
`timescale 1ns / 1ps
`default_nettype none
package sha1md_pkg;

  localparam int WordW   = 32;
  localparam int BlkWrds = 16;
  localparam int Rounds  = 80;
  localparam int TotalW  = 61;

  localparam logic [WordW-1:0] InitChain [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadMark = 8'h80;

  // Control from the sequencer to the schedule shift line
  typedef struct packed {
    logic       shift_byte;
    logic       shift_round;
    logic [7:0] data;
  } sched_ctrl_t;

  function automatic logic [WordW-1:0] rotl1(input logic [WordW-1:0] v);
    return {v[WordW-2:0], v[WordW-1]};
  endfunction

endpackage
`default_nettype wire

// ===== src/sha1md_sched.sv =====
// Block buffer and message schedule: a 16-word shift line.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_sched (
  input  wire logic                        clk,
  input  wire sha1md_pkg::sched_ctrl_t     ctrl,
  output logic [sha1md_pkg::WordW-1:0]     w_cur
);

  logic [sha1md_pkg::WordW-1:0] words [sha1md_pkg::BlkWrds];
  logic [sha1md_pkg::WordW-1:0] w_new;

  // W[t+16] from taps t+13, t+8, t+2, t
  assign w_new = sha1md_pkg::rotl1(words[13] ^ words[8] ^ words[2] ^ words[0]);
  assign w_cur = words[0];

  always_ff @(posedge clk) begin
    if (ctrl.shift_byte) begin
      // bytes enter big-endian; the whole block moves up one byte
      for (int i = 0; i < sha1md_pkg::BlkWrds - 1; i++) begin
        words[i] <= {words[i][23:0], words[i+1][31:24]};
      end
      words[sha1md_pkg::BlkWrds-1] <= {words[sha1md_pkg::BlkWrds-1][23:0], ctrl.data};
    end else if (ctrl.shift_round) begin
      for (int i = 0; i < sha1md_pkg::BlkWrds - 1; i++) begin
        words[i] <= words[i+1];
      end
      words[sha1md_pkg::BlkWrds-1] <= w_new;
    end
  end

endmodule
`default_nettype wire

// ===== src/sha1_message_digest_top.sv =====
// SHA-1 digest engine: byte input, 160-bit digest output, round sequencer.
//
// Input channel: in_valid / in_stall with data_byte, has_byte, last. An item
// is taken when in_valid is high and in_stall low. A byte item without last
// that does not close a 64-byte block leaves in_stall low.
// When a byte fills the block, the compression runs one round per cycle on a
// single shared round adder: 80 rounds and then the chaining add, with
// in_stall high throughout.
// An item with last set pads the message one byte per cycle through the
// block shift line, then compresses; one or two final blocks. When the
// marker lands on byte 56 or later, a second block carries the length;
// the digest is then loaded once the output register is free.
// An item with has_byte and last both clear changes nothing.
// Output channel: out_valid / out_stall with digest_word0..4, held in an
// output register. Once the digest is copied there the engine starts the next
// message at once; a new digest waits only if the previous one is still
// stalled. No byte is taken while the engine pads, compresses or emits.
// Reset (rst, synchronous): chaining words back to the initial values, the
// byte count cleared, no result pending, ready for a new message.
`timescale 1ns / 1ps
`default_nettype none
module sha1_message_digest_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word0,
  output logic [31:0]      digest_word1,
  output logic [31:0]      digest_word2,
  output logic [31:0]      digest_word3,
  output logic [31:0]      digest_word4
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_PAD,
    S_EMIT
  } state_t;

  localparam logic [6:0] LastRound = 7'(sha1md_pkg::Rounds - 1);

  state_t state;

  logic [sha1md_pkg::WordW-1:0]  chain [5];
  logic [sha1md_pkg::WordW-1:0]  work  [5];
  logic [sha1md_pkg::TotalW-1:0] byte_total;
  logic [5:0]                    blk_pos;    // next byte slot in the block
  logic [6:0]                    rnd;
  logic                          fin;        // message is being closed
  logic                          sent80;     // pad marker placed
  logic                          len_ok;     // length fits in this block
  logic                          final_blk;  // block holds the length

  logic                          accept;
  logic                          out_free;
  logic [7:0]                    pad_byte;
  logic [63:0]                   len_bits;
  logic [2:0]                    len_sel;
  logic [sha1md_pkg::WordW-1:0]  w_cur;
  logic [sha1md_pkg::WordW-1:0]  f_val;
  logic [sha1md_pkg::WordW-1:0]  k_val;
  logic [sha1md_pkg::WordW-1:0]  t_val;
  sha1md_pkg::sched_ctrl_t       sctrl;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // padding byte: marker, then zeros, then the 64-bit bit length
  assign len_bits = {byte_total, 3'b000};
  assign len_sel  = 3'd7 - blk_pos[2:0];

  always_comb begin
    if (!sent80) begin
      pad_byte = sha1md_pkg::PadMark;
    end else if (len_ok && (blk_pos >= 6'd56)) begin
      pad_byte = len_bits[{len_sel, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    sctrl.shift_byte  = (accept && has_byte) || (state == S_PAD);
    sctrl.shift_round = (state == S_ROUND);
    sctrl.data        = (state == S_PAD) ? pad_byte : data_byte;
  end

  sha1md_sched u_sched (
    .clk   (clk),
    .ctrl  (sctrl),
    .w_cur (w_cur)
  );

  // one round: f from b, c, d, with f and k selected by round group
  always_comb begin
    if (rnd < 7'd20) begin
      f_val = (work[1] & work[2]) | (~work[1] & work[3]);
      k_val = sha1md_pkg::K0;
    end else if (rnd < 7'd40) begin
      f_val = work[1] ^ work[2] ^ work[3];
      k_val = sha1md_pkg::K1;
    end else if (rnd < 7'd60) begin
      f_val = (work[1] & work[2]) | (work[1] & work[3]) | (work[2] & work[3]);
      k_val = sha1md_pkg::K2;
    end else begin
      f_val = work[1] ^ work[2] ^ work[3];
      k_val = sha1md_pkg::K3;
    end
    t_val = {work[0][26:0], work[0][31:27]} + f_val + work[4] + k_val + w_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_total <= '0;
      blk_pos    <= '0;
      rnd        <= '0;
      fin        <= 1'b0;
      sent80     <= 1'b0;
      len_ok     <= 1'b0;
      final_blk  <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        chain[i] <= sha1md_pkg::InitChain[i];
        work[i]  <= '0;
      end
    end else begin
      // output register: emptied on a take, refilled from S_EMIT
      if (out_free) begin
        out_valid <= (state == S_EMIT);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            fin       <= last;
            sent80    <= 1'b0;
            final_blk <= 1'b0;
            if (has_byte) begin
              byte_total <= byte_total + 1'b1;
              blk_pos    <= blk_pos + 1'b1;
            end
            if (has_byte && (blk_pos == 6'd63)) begin
              for (int i = 0; i < 5; i++) begin
                work[i] <= chain[i];
              end
              state <= S_ROUND;
            end else if (last) begin
              state <= S_PAD;
            end
          end
        end
        S_ROUND: begin
          work[0] <= t_val;
          work[1] <= work[0];
          work[2] <= {work[1][1:0], work[1][31:2]};
          work[3] <= work[2];
          work[4] <= work[3];
          if (rnd == LastRound) begin
            rnd   <= '0;
            state <= S_ADD;
          end else begin
            rnd <= rnd + 1'b1;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 5; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          if (!fin) begin
            state <= S_IDLE;
          end else if (final_blk) begin
            state <= S_EMIT;
          end else begin
            // length goes in the fresh block
            len_ok <= 1'b1;
            state  <= S_PAD;
          end
        end
        S_PAD: begin
          blk_pos <= blk_pos + 1'b1;
          if (!sent80) begin
            sent80 <= 1'b1;
            len_ok <= (blk_pos < 6'd56);
          end
          if (blk_pos == 6'd63) begin
            final_blk <= sent80 && len_ok;
            for (int i = 0; i < 5; i++) begin
              work[i] <= chain[i];
            end
            state <= S_ROUND;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            digest_word0 <= chain[0];
            digest_word1 <= chain[1];
            digest_word2 <= chain[2];
            digest_word3 <= chain[3];
            digest_word4 <= chain[4];
            for (int i = 0; i < 5; i++) begin
              chain[i] <= sha1md_pkg::InitChain[i];
            end
            byte_total <= '0;
            blk_pos    <= '0;
            fin        <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // round counter never runs past the last round
  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    rnd <= LastRound)
    else $error("round counter out of range");

  // chaining add only straight after the last round
  a_add_after_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |-> ($past(state) == S_ROUND && $past(rnd) == LastRound))
    else $error("chaining add without a full round pass");

  // between items the block slot tracks the message byte count
  a_pos_tracks_total: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (byte_total[5:0] == blk_pos))
    else $error("block position out of step with byte count");

  // a digest is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && state == S_EMIT) |=> (state == S_EMIT))
    else $error("digest register overwritten while stalled");

endmodule
`default_nettype wire
